FILE: design/pps_pkg.sv
`timescale 1ns / 1ps

package pps_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_END   = 2'd1,
    REQ_SCHED = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_READY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_NOEND  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE   = 3'd0,
    S_DECODE = 3'd1,
    S_SCAN   = 3'd2,
    S_DECIDE = 3'd3,
    S_DONE   = 3'd4
  } state_t;

  // Sequencer strobes shared by the datapath
  typedef struct packed {
    logic ready;     // waiting for a request
    logic decode;    // request held, checks and start insertion
    logic rd_en;     // list read issued this cycle
    logic data_v;    // list read data valid this cycle
    logic decide;    // apply the selection result
    logic load_out;  // move the result into the output register
  } ctrl_t;

endpackage

FILE: design/priority_preemptive_scheduler.sv
`timescale 1ns / 1ps

// Preemptive priority scheduler. Each request on the in_ channel (start, end,
// schedule or the unused kind) yields exactly one result on the out_ channel
// (running task, dispatched flag, switch flag, status). The ready list sits in
// a small memory with one read and one write port, walked one entry per cycle
// by one compare unit; an end request removes the running task and picks the
// next one in that same walk. A start request (or one that needs no selection)
// goes from the decode state straight to the done state; schedule requests and
// end requests that are taken walk the list and pass the decide state first.
// The block takes no new request until the current one has moved into the
// output register, which may still wait for out_tready while the next request
// is accepted.
module priority_preemptive_scheduler #(
  parameter int MAX_TASKS = 16,
  parameter int PRIO_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [3:0] task_id, [11:4] priority_req, [15:12] zero
  input  logic [1:0]  in_tuser,   // [1:0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata   // [3:0] running_task, [4] has_running, [5] switched,
                                  // [7:6] status
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);
  localparam int PW = PRIO_BITS;
  localparam int EW = 4 + PW;

  pps_pkg::ctrl_t  ctrl;
  pps_pkg::req_t   req_r;
  pps_pkg::status_t status_nxt, status_r;
  logic [3:0]      tid_r;
  logic [PW-1:0]   prio_r;

  logic [CW-1:0]        count_r;
  logic [MAX_TASKS-1:0] ready_r;
  logic [3:0]           cur_task_r;
  logic [PW-1:0]        cur_prio_r;
  logic                 cur_valid_r;
  logic                 killed_r;
  logic                 sw_r;
  logic                 out_valid_r;
  logic [7:0]           out_data_r;

  logic [AW-1:0] tid_idx, cur_idx, rd_addr, data_idx;
  logic          end_ok, start_ok, end_go, go_scan, out_free;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [EW-1:0] mem_wdata, mem_rdata;

  logic          best_v, found, shift_we;
  logic [3:0]    best_tid, pick_tid;
  logic [PW-1:0] best_prio, pick_prio;
  logic [AW-1:0] shift_addr;
  logic          no_op, sw_now;

  assign tid_idx  = AW'(tid_r);
  assign cur_idx  = AW'(cur_task_r);
  assign out_free = !out_valid_r || out_tready;

  assign end_ok   = cur_valid_r && (cur_task_r != 4'd0) && (int'(cur_task_r) < MAX_TASKS);

  always_comb begin
    status_nxt = pps_pkg::ST_OK;
    case (req_r)
      pps_pkg::REQ_START: begin
        if (tid_r == 4'd0) begin
          status_nxt = pps_pkg::ST_READY;
        end else if (int'(tid_r) >= MAX_TASKS) begin
          status_nxt = pps_pkg::ST_FULL;
        end else if (ready_r[tid_idx]) begin
          status_nxt = pps_pkg::ST_READY;
        end else if (count_r >= CW'(MAX_TASKS)) begin
          status_nxt = pps_pkg::ST_FULL;
        end
      end
      pps_pkg::REQ_END: begin
        if (!end_ok) status_nxt = pps_pkg::ST_NOEND;
      end
      default: begin
        status_nxt = pps_pkg::ST_OK;
      end
    endcase
  end

  assign start_ok = (req_r == pps_pkg::REQ_START) && (status_nxt == pps_pkg::ST_OK);
  assign end_go   = (req_r == pps_pkg::REQ_END) && end_ok;
  assign go_scan  = end_go || (req_r == pps_pkg::REQ_SCHED);

  // Selection result; an empty list picks the idle task at priority zero
  assign pick_tid  = best_v ? best_tid : 4'd0;
  assign pick_prio = best_v ? best_prio : '0;
  assign no_op     = cur_valid_r && (pick_tid == 4'd0) && (cur_task_r == 4'd0);
  assign sw_now    = !no_op && (!cur_valid_r || (pick_prio > cur_prio_r) || killed_r);

  assign mem_we    = (ctrl.decode && start_ok) || shift_we;
  assign mem_waddr = shift_we ? shift_addr : count_r[AW-1:0];
  assign mem_wdata = shift_we ? mem_rdata : {tid_r, prio_r};

  pps_seq #(
    .MAX_TASKS(MAX_TASKS)
  ) u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .go_scan  (go_scan),
    .out_free (out_free),
    .count    (count_r),
    .ctrl     (ctrl),
    .rd_addr  (rd_addr),
    .data_idx (data_idx)
  );

  pps_list_mem #(
    .DEPTH (MAX_TASKS),
    .AW    (AW),
    .DW    (EW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_addr),
    .rdata (mem_rdata)
  );

  pps_pick #(
    .PW (PW),
    .AW (AW)
  ) u_pick (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctrl       (ctrl),
    .rm_en      (req_r == pps_pkg::REQ_END),
    .cur_tid    (cur_task_r),
    .ent_tid    (mem_rdata[EW-1:PW]),
    .ent_prio   (mem_rdata[PW-1:0]),
    .ent_idx    (data_idx),
    .best_v     (best_v),
    .best_tid   (best_tid),
    .best_prio  (best_prio),
    .found      (found),
    .shift_we   (shift_we),
    .shift_addr (shift_addr)
  );

  // Request and result payload
  always_ff @(posedge clk) begin
    if (ctrl.ready && in_tvalid) begin
      req_r  <= pps_pkg::req_t'(in_tuser);
      tid_r  <= in_tdata[3:0];
      prio_r <= PW'(in_tdata[11:4]);
    end
    if (ctrl.decode) begin
      status_r <= status_nxt;
      sw_r     <= 1'b0;
    end else if (ctrl.decide) begin
      sw_r <= sw_now;
    end
    if (ctrl.load_out) begin
      out_data_r <= {status_r, sw_r, cur_valid_r, cur_task_r};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      ready_r     <= '0;
      cur_task_r  <= 4'd0;
      cur_prio_r  <= '0;
      cur_valid_r <= 1'b0;
      killed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (ctrl.decode && start_ok) begin
        ready_r[tid_idx] <= 1'b1;
        count_r          <= count_r + 1'b1;
      end
      if (ctrl.decode && end_go) begin
        ready_r[cur_idx] <= 1'b0;
        killed_r         <= 1'b1;
      end
      if (ctrl.decide) begin
        if (found) count_r <= count_r - 1'b1;
        if (sw_now) begin
          cur_task_r  <= pick_tid;
          cur_prio_r  <= pick_prio;
          cur_valid_r <= 1'b1;
          killed_r    <= 1'b0;
        end
      end
      if (ctrl.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign in_tready  = ctrl.ready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The list never holds more tasks than it has slots
  assert property (@(posedge clk) disable iff (!rst_n) count_r <= CW'(MAX_TASKS))
    else $error("list count above capacity");

  // Between requests the running task, if any, is on the ready list
  assert property (@(posedge clk) disable iff (!rst_n)
    (ctrl.ready && cur_valid_r && (cur_task_r != 4'd0)) |-> ready_r[cur_idx])
    else $error("running task missing from ready list");

  // An ended task always gives way before the request completes
  assert property (@(posedge clk) disable iff (!rst_n) ctrl.ready |-> !killed_r)
    else $error("killed task still running between requests");

  // List entries move down only during a removal walk
  assert property (@(posedge clk) disable iff (!rst_n)
    shift_we |-> (found && (req_r == pps_pkg::REQ_END)))
    else $error("list shift outside removal");

endmodule

FILE: design/pps_list_mem.sv
`timescale 1ns / 1ps

module pps_list_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 12
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/pps_pick.sv
`timescale 1ns / 1ps

module pps_pick #(
  parameter int PW = 8,
  parameter int AW = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  pps_pkg::ctrl_t ctrl,
  input  logic           rm_en,
  input  logic [3:0]     cur_tid,
  input  logic [3:0]     ent_tid,
  input  logic [PW-1:0]  ent_prio,
  input  logic [AW-1:0]  ent_idx,
  output logic           best_v,
  output logic [3:0]     best_tid,
  output logic [PW-1:0]  best_prio,
  output logic           found,
  output logic           shift_we,
  output logic [AW-1:0]  shift_addr
);

  logic          best_v_r;
  logic [3:0]    best_tid_r;
  logic [PW-1:0] best_prio_r;
  logic          found_r;
  logic          hit;

  // The entry being removed is skipped; everything after it moves down one slot
  assign hit        = rm_en && !found_r && (ent_tid == cur_tid);
  assign shift_we   = ctrl.data_v && !hit && found_r;
  assign shift_addr = ent_idx - 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      best_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (ctrl.decode) begin
      best_v_r <= 1'b0;
      found_r  <= 1'b0;
    end else if (ctrl.data_v) begin
      if (hit) begin
        found_r <= 1'b1;
      end else if (!best_v_r || (ent_prio > best_prio_r)) begin
        // strict compare keeps the first of equal priorities
        best_v_r    <= 1'b1;
        best_tid_r  <= ent_tid;
        best_prio_r <= ent_prio;
      end
    end
  end

  assign best_v    = best_v_r;
  assign best_tid  = best_tid_r;
  assign best_prio = best_prio_r;
  assign found     = found_r;

endmodule

FILE: design/pps_seq.sv
`timescale 1ns / 1ps

module pps_seq #(
  parameter int MAX_TASKS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  input  logic                                 go_scan,
  input  logic                                 out_free,
  input  logic [$clog2(MAX_TASKS+1)-1:0]       count,
  output pps_pkg::ctrl_t                       ctrl,
  output logic [$clog2(MAX_TASKS)-1:0]         rd_addr,
  output logic [$clog2(MAX_TASKS)-1:0]         data_idx
);

  localparam int AW = $clog2(MAX_TASKS);
  localparam int CW = $clog2(MAX_TASKS + 1);

  pps_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   scan_r;
  logic            data_v_r;
  logic [AW-1:0]   data_idx_r;
  logic            issue;

  assign issue = (state_r == pps_pkg::S_SCAN) && (scan_r < count);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pps_pkg::S_IDLE: begin
        if (in_valid) state_nxt = pps_pkg::S_DECODE;
      end
      pps_pkg::S_DECODE: begin
        state_nxt = go_scan ? pps_pkg::S_SCAN : pps_pkg::S_DONE;
      end
      pps_pkg::S_SCAN: begin
        if (!issue && !data_v_r) state_nxt = pps_pkg::S_DECIDE;
      end
      pps_pkg::S_DECIDE: begin
        state_nxt = pps_pkg::S_DONE;
      end
      pps_pkg::S_DONE: begin
        if (out_free) state_nxt = pps_pkg::S_IDLE;
      end
      default: begin
        state_nxt = pps_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    ctrl          = '0;
    ctrl.rd_en    = issue;
    ctrl.data_v   = data_v_r;
    case (state_r)
      pps_pkg::S_IDLE:   ctrl.ready    = 1'b1;
      pps_pkg::S_DECODE: ctrl.decode   = 1'b1;
      pps_pkg::S_DECIDE: ctrl.decide   = 1'b1;
      pps_pkg::S_DONE:   ctrl.load_out = out_free;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= pps_pkg::S_IDLE;
      scan_r   <= '0;
      data_v_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      data_v_r <= issue;
      if (state_r == pps_pkg::S_DECODE) begin
        scan_r <= '0;
      end else if (issue) begin
        scan_r <= scan_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_idx_r <= scan_r[AW-1:0];
  end

  assign rd_addr  = scan_r[AW-1:0];
  assign data_idx = data_idx_r;

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

  localparam int NUM_TASKS   = 16;
  localparam int RAND_REQS   = 1900;
  localparam int WD_LIMIT    = 2000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    pps_pkg::status_t status;
    logic             switched;
    logic             has_running;
    logic [3:0]       running;
  } dispatch_t;

  typedef struct {
    pps_pkg::req_t req;
    logic [3:0]    tid;
    logic [7:0]    prio;
    bit            fixed;
    dispatch_t     exp;
  } req_row_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [7:0]  out_tdata;

  priority_preemptive_scheduler i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Scheduler shadow state
  logic [3:0] ready_list[$];
  bit         ready_set[NUM_TASKS];
  logic [7:0] prio_tab[NUM_TASKS];
  logic [3:0] cur_task;
  bit         cur_valid;
  bit         cur_killed;

  dispatch_t  dispatch_q[$];
  req_row_t   directed[$];

  bit         drv_fixed;
  dispatch_t  drv_exp;
  bit         quiet;
  int         stall_left;
  int         stuck;
  int         err_count;
  int         n_start, n_end, n_sched, n_ignored;
  int         n_checked, n_switch, n_noend, n_dup;
  dispatch_t  got, want, pred;

  function automatic logic [7:0] prio_of(logic [3:0] t);
    return (t == 4'd0) ? 8'd0 : prio_tab[t];
  endfunction

  // Pick the first task with the strictly highest priority and decide on a switch
  function automatic bit reschedule();
    logic [3:0] pick;
    pick = 4'd0;
    if (ready_list.size() != 0) begin
      pick = ready_list[0];
      for (int i = 1; i < ready_list.size(); i++) begin
        if (prio_of(ready_list[i]) > prio_of(pick)) pick = ready_list[i];
      end
    end
    if (cur_valid && pick == 4'd0 && cur_task == 4'd0) return 1'b0;
    if (!cur_valid || prio_of(pick) > prio_of(cur_task) || cur_killed) begin
      cur_task   = pick;
      cur_valid  = 1'b1;
      cur_killed = 1'b0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic dispatch_t dispatch_step(pps_pkg::req_t req, logic [3:0] tid,
                                              logic [7:0] prio);
    dispatch_t r;
    r = '0;
    r.status = pps_pkg::ST_OK;
    case (req)
      pps_pkg::REQ_START: begin
        if (tid == 4'd0 || ready_set[tid]) begin
          r.status = pps_pkg::ST_READY;
        end else if (ready_list.size() >= NUM_TASKS) begin
          r.status = pps_pkg::ST_FULL;
        end else begin
          ready_set[tid] = 1'b1;
          prio_tab[tid]  = prio;
          ready_list.push_back(tid);
        end
      end
      pps_pkg::REQ_END: begin
        if (!cur_valid || cur_task == 4'd0) begin
          r.status = pps_pkg::ST_NOEND;
        end else begin
          ready_set[cur_task] = 1'b0;
          cur_killed = 1'b1;
          for (int i = 0; i < ready_list.size(); i++) begin
            if (ready_list[i] == cur_task) begin
              ready_list.delete(i);
              break;
            end
          end
          r.switched = reschedule();
        end
      end
      pps_pkg::REQ_SCHED: r.switched = reschedule();
      default: ;
    endcase
    r.running     = cur_task;
    r.has_running = cur_valid;
    return r;
  endfunction

  function automatic dispatch_t mk_res(logic [3:0] running, logic has, logic sw,
                                       pps_pkg::status_t st);
    dispatch_t r;
    r.running     = running;
    r.has_running = has;
    r.switched    = sw;
    r.status      = st;
    return r;
  endfunction

  task automatic add_row(pps_pkg::req_t req, logic [3:0] tid, logic [7:0] prio, bit fixed,
                         dispatch_t exp);
    req_row_t row;
    row.req   = req;
    row.tid   = tid;
    row.prio  = prio;
    row.fixed = fixed;
    row.exp   = exp;
    directed.push_back(row);
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    err_count++;
  endtask

  // Mostly back to back, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic issue_request(pps_pkg::req_t req, logic [3:0] tid, logic [7:0] prio,
                               bit fixed, dispatch_t exp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid = 1'b1;
    in_tuser  = req;
    in_tdata  = {4'b0000, prio, tid};
    drv_fixed = fixed;
    drv_exp   = exp;
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  function automatic logic [7:0] rand_prio();
    int r;
    r = $urandom_range(0, 7);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    if (r == 2) return 8'($urandom_range(0, 3));
    return 8'($urandom_range(0, 255));
  endfunction

  // Result sink stalls
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left <= idle_len();
    end
  end

  // Check results, then predict the request taken at this edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got = dispatch_t'(out_tdata);
        if (dispatch_q.size() == 0) begin
          report_mismatch($sformatf("result 0x%02h with no request pending", out_tdata));
        end else begin
          want = dispatch_q.pop_front();
          n_checked++;
          if (got.running !== want.running)
            report_mismatch($sformatf("running_task %0d, want %0d", got.running, want.running));
          if (got.has_running !== want.has_running)
            report_mismatch($sformatf("has_running %0b, want %0b",
                                      got.has_running, want.has_running));
          if (got.switched !== want.switched)
            report_mismatch($sformatf("switched %0b, want %0b", got.switched, want.switched));
          if (got.status !== want.status)
            report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
          if (got.switched === 1'b1) n_switch++;
        end
      end
      if (in_tvalid && in_tready) begin
        pred = dispatch_step(pps_pkg::req_t'(in_tuser), in_tdata[3:0], in_tdata[11:4]);
        dispatch_q.push_back(drv_fixed ? drv_exp : pred);
        case (pps_pkg::req_t'(in_tuser))
          pps_pkg::REQ_START: n_start++;
          pps_pkg::REQ_END:   n_end++;
          pps_pkg::REQ_SCHED: n_sched++;
          default:            n_ignored++;
        endcase
        if (pred.status == pps_pkg::ST_NOEND) n_noend++;
        if (pred.status == pps_pkg::ST_READY) n_dup++;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) stuck <= 0;
    else stuck <= stuck + 1;
    if (stuck >= WD_LIMIT) begin
      $display("[%0t] watchdog: no transfer for %0d cycles, %0d results pending",
               $realtime, WD_LIMIT, dispatch_q.size());
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int made;
    pps_pkg::req_t rq;
    int r;
    rst_n      = 1'b0;
    in_tvalid  = 1'b0;
    in_tdata   = '0;
    in_tuser   = '0;
    out_tready = 1'b0;
    drv_fixed  = 1'b0;
    drv_exp    = '0;
    quiet      = 1'b0;
    stall_left = 0;
    stuck      = 0;
    err_count  = 0;
    n_start = 0; n_end = 0; n_sched = 0; n_ignored = 0;
    n_checked = 0; n_switch = 0; n_noend = 0; n_dup = 0;
    for (int i = 0; i < NUM_TASKS; i++) begin
      ready_set[i] = 1'b0;
      prio_tab[i]  = '0;
    end
    cur_task   = '0;
    cur_valid  = 1'b0;
    cur_killed = 1'b0;

    // Directed: empty scheduler, idle task, ties, preemption and draining the list
    add_row(pps_pkg::REQ_END, 4'd0, 8'd0, 1, mk_res(4'd0, 1'b0, 1'b0, pps_pkg::ST_NOEND));
    add_row(pps_pkg::REQ_NONE, 4'd15, 8'd255, 1, mk_res(4'd0, 1'b0, 1'b0, pps_pkg::ST_OK));
    add_row(pps_pkg::REQ_START, 4'd0, 8'd255, 1,
            mk_res(4'd0, 1'b0, 1'b0, pps_pkg::ST_READY));
    add_row(pps_pkg::REQ_SCHED, 4'd0, 8'd0, 1, mk_res(4'd0, 1'b1, 1'b1, pps_pkg::ST_OK));
    add_row(pps_pkg::REQ_SCHED, 4'd0, 8'd0, 1, mk_res(4'd0, 1'b1, 1'b0, pps_pkg::ST_OK));
    add_row(pps_pkg::REQ_END, 4'd0, 8'd0, 1, mk_res(4'd0, 1'b1, 1'b0, pps_pkg::ST_NOEND));
    add_row(pps_pkg::REQ_START, 4'd15, 8'd255, 1,
            mk_res(4'd0, 1'b1, 1'b0, pps_pkg::ST_OK));
    add_row(pps_pkg::REQ_START, 4'd15, 8'd3, 1,
            mk_res(4'd0, 1'b1, 1'b0, pps_pkg::ST_READY));
    add_row(pps_pkg::REQ_START, 4'd1,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_START, 4'd2,  8'd255, 0, '0);
    add_row(pps_pkg::REQ_SCHED, 4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_START, 4'd3,  8'hAA,  0, '0);
    add_row(pps_pkg::REQ_START, 4'd4,  8'h55,  0, '0);
    add_row(pps_pkg::REQ_SCHED, 4'd9,  8'd1,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_START, 4'd5,  8'hFE,  0, '0);
    add_row(pps_pkg::REQ_SCHED, 4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_END,   4'd0,  8'd0,   0, '0);
    add_row(pps_pkg::REQ_SCHED, 4'd0,  8'd0,   0, '0);

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (directed[i])
      issue_request(directed[i].req, directed[i].tid, directed[i].prio,
                    directed[i].fixed, directed[i].exp);

    made = 0;
    while (made < RAND_REQS) begin
      if (made % 150 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      if (r < 50)      rq = pps_pkg::REQ_START;
      else if (r < 75) rq = pps_pkg::REQ_END;
      else if (r < 95) rq = pps_pkg::REQ_SCHED;
      else             rq = pps_pkg::REQ_NONE;
      if (rq != pps_pkg::REQ_NONE) made++;
      issue_request(rq, ($urandom_range(0, 29) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
                    rand_prio(), 1'b0, '0);
    end
    in_tvalid = 1'b0;
    quiet     = 1'b0;

    while (dispatch_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d requests: %0d start, %0d end, %0d schedule, %0d unused kind.",
             n_start + n_end + n_sched + n_ignored, n_start, n_end, n_sched, n_ignored);
    $display("Checked %0d results: %0d task switches, %0d refused ends, %0d duplicate starts.",
             n_checked, n_switch, n_noend, n_dup);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
